@@ sv/distance_window_hit_clustering_defines.svh @@
// Assertion macros for the hit clustering block.
`ifndef DISTANCE_WINDOW_HIT_CLUSTERING_DEFINES_SVH
`define DISTANCE_WINDOW_HIT_CLUSTERING_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define DWHC_ASSERT(name, clock, rstn, prop, msg) \
  name: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define DWHC_NEVER(name, clock, rstn, cond, msg) \
  name: assert property (@(posedge clock) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define DWHC_ASSERT(name, clock, rstn, prop, msg)
`define DWHC_NEVER(name, clock, rstn, cond, msg)

`endif

`endif

@@ sv/dwhc_pkg.sv @@
package dwhc_pkg;

  // Window register.
  localparam int WIN_W = 34;
  localparam logic [WIN_W-1:0] WIN_RESET = 34'd256;

  // Result fields.
  localparam int IDX_W     = 6;
  localparam int LBL_W     = 6;
  localparam int OUT_DATA_W = 16;

endpackage

@@ sv/distance_window_hit_clustering.sv @@
// Friends-of-friends hit clustering. Hits (x, y, z, signed fixed point) load one per
// cycle while in_tready is high into a hit memory; hits without the available flag
// are skipped, and available hits beyond MAX_HITS are dropped and reported through
// the overflow flag of every result. The beat carrying tlast starts a run on the n
// stored hits: a pair pass through the single read port of the hit memory builds one
// adjacency row per hit, linking pairs whose squared distance is strictly below
// window_squared; a labeling pass walks each component from the adjacency memory,
// visiting each seed index in turn and picking then merging each hit it reaches;
// then n results leave in load order, each held until the sink takes it. No hit is
// taken until the last result has left. A tlast with no stored hits returns nothing.
// The window register may be written only while the block is idle.
`include "distance_window_hit_clustering_defines.svh"

module distance_window_hit_clustering
  import dwhc_pkg::*;
#(
  parameter int MAX_HITS   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata fields, low bit up: pos_x, pos_y, pos_z, zero fill
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tuser,  // available
  input  logic                                  in_tlast,  // last_hit
  // out_tdata fields, low bit up: hit_index, cluster_label, zero fill
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [OUT_DATA_W-1:0]                 out_tdata,
  output logic                                  out_tuser, // overflow
  output logic                                  out_tlast, // last_result
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [WIN_W-1:0]                      cfg_data
);

  localparam int AW   = $clog2(MAX_HITS);
  localparam int CW   = $clog2(MAX_HITS + 1);
  localparam int CB   = COORD_BITS;
  localparam int HW   = 3 * CB;
  localparam int DW   = CB + 1;
  localparam int SQW  = 2 * DW;
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > WIN_W) ? SUMW : WIN_W;

  typedef enum logic [3:0] {
    S_LOAD, S_ROWA, S_ROWB, S_ROWC, S_SEED, S_PICK, S_MERGE, S_ORD, S_OLD, S_OWAIT
  } state_t;

  state_t state_r;

  logic [WIN_W-1:0] win_r;

  // Memories.
  logic [HW-1:0]       hit_mem [MAX_HITS];
  logic [MAX_HITS-1:0] adj_mem [MAX_HITS];
  logic [AW-1:0]       lbl_mem [MAX_HITS];

  logic [HW-1:0]       hit_rdata_r;
  logic [MAX_HITS-1:0] adj_rdata_r;
  logic [AW-1:0]       lbl_rdata_r;

  logic [CW-1:0]       cnt_r;
  logic                drop_r;

  // Pair pass.
  logic [CW-1:0]       bi_r;
  logic [CW-1:0]       bj_r;
  logic [HW-1:0]       pi_r;
  logic                v1_r, v2_r;
  logic [AW-1:0]       j1_r, j2_r;
  logic [SQW-1:0]      sqx_r, sqy_r, sqz_r;
  logic [MAX_HITS-1:0] row_r;

  // Labeling pass.
  logic [CW-1:0]       si_r;
  logic [MAX_HITS-1:0] done_r, front_r;
  logic [AW-1:0]       lbl_next_r;

  // Output.
  logic [CW-1:0]       ok_r;
  logic                ovalid_r;
  logic [IDX_W-1:0]    oidx_r;
  logic [LBL_W-1:0]    olbl_r;
  logic                oflow_r, olast_r;

  function automatic logic [AW-1:0] lowest(input logic [MAX_HITS-1:0] v);
    logic [AW-1:0] idx;
    idx = '0;
    for (int k = MAX_HITS - 1; k >= 0; k--) begin
      if (v[k]) idx = AW'(k);
    end
    return idx;
  endfunction

  logic               in_acc;
  logic               store_ok;
  logic [CW-1:0]      cnt_after;
  logic               issue;
  logic [AW-1:0]      hit_raddr;
  logic [AW-1:0]      pick_idx;
  logic signed [DW-1:0] dx, dy, dz;
  logic [CMPW-1:0]    dist_sum;
  logic [MAX_HITS-1:0] grow;

  assign in_tready = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign store_ok  = in_tuser && (cnt_r < CW'(MAX_HITS));
  assign cnt_after = store_ok ? cnt_r + CW'(1) : cnt_r;
  assign issue     = (state_r == S_ROWC) && (bj_r < cnt_r);
  assign hit_raddr = (state_r == S_ROWA) ? bi_r[AW-1:0] : bj_r[AW-1:0];
  assign pick_idx  = lowest(front_r);
  assign grow      = adj_rdata_r & ~done_r;

  // Coordinate differences against the row hit.
  assign dx = DW'(signed'(pi_r[CB-1:0]))      - DW'(signed'(hit_rdata_r[CB-1:0]));
  assign dy = DW'(signed'(pi_r[2*CB-1:CB]))   - DW'(signed'(hit_rdata_r[2*CB-1:CB]));
  assign dz = DW'(signed'(pi_r[3*CB-1:2*CB])) - DW'(signed'(hit_rdata_r[3*CB-1:2*CB]));
  assign dist_sum = CMPW'(sqx_r) + CMPW'(sqy_r) + CMPW'(sqz_r);

  // Hit memory.
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) hit_mem[cnt_r[AW-1:0]] <= in_tdata[HW-1:0];
    hit_rdata_r <= hit_mem[hit_raddr];
  end

  // Adjacency memory.
  always_ff @(posedge clk) begin
    if (state_r == S_ROWC && !issue && !v1_r && !v2_r) adj_mem[bi_r[AW-1:0]] <= row_r;
    adj_rdata_r <= adj_mem[pick_idx];
  end

  // Label memory.
  always_ff @(posedge clk) begin
    if (state_r == S_PICK && front_r != '0) lbl_mem[pick_idx] <= lbl_next_r;
    lbl_rdata_r <= lbl_mem[ok_r[AW-1:0]];
  end

  // Squares of the differences.
  always_ff @(posedge clk) begin
    sqx_r <= SQW'(dx * dx);
    sqy_r <= SQW'(dy * dy);
    sqz_r <= SQW'(dz * dz);
    j2_r  <= j1_r;
  end

  // Control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      win_r    <= WIN_RESET;
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) win_r <= cfg_data;
      v1_r <= issue;
      v2_r <= v1_r;
      j1_r <= bj_r[AW-1:0];
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            cnt_r <= cnt_after;
            if (in_tuser && !store_ok) drop_r <= 1'b1;
            if (in_tlast) begin
              bi_r <= '0;
              if (cnt_after == '0) begin
                drop_r <= 1'b0;
              end else begin
                state_r <= S_ROWA;
              end
            end
          end
        end
        S_ROWA: state_r <= S_ROWB;
        S_ROWB: begin
          pi_r    <= hit_rdata_r;
          bj_r    <= '0;
          row_r   <= '0;
          state_r <= S_ROWC;
        end
        S_ROWC: begin
          if (issue) bj_r <= bj_r + CW'(1);
          // Set a link bit for a close pair other than the hit itself.
          if (v2_r && (dist_sum < CMPW'(win_r)) && (j2_r != bi_r[AW-1:0])) begin
            row_r[j2_r] <= 1'b1;
          end
          if (!issue && !v1_r && !v2_r) begin
            bi_r <= bi_r + CW'(1);
            if (bi_r + CW'(1) == cnt_r) begin
              si_r       <= '0;
              done_r     <= '0;
              lbl_next_r <= '0;
              state_r    <= S_SEED;
            end else begin
              state_r <= S_ROWA;
            end
          end
        end
        S_SEED: begin
          if (si_r == cnt_r) begin
            ok_r    <= '0;
            state_r <= S_ORD;
          end else if (done_r[si_r[AW-1:0]]) begin
            si_r <= si_r + CW'(1);
          end else begin
            front_r <= {{(MAX_HITS-1){1'b0}}, 1'b1} << si_r[AW-1:0];
            done_r[si_r[AW-1:0]]  <= 1'b1;
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (front_r == '0) begin
            lbl_next_r <= lbl_next_r + AW'(1);
            si_r       <= si_r + CW'(1);
            state_r    <= S_SEED;
          end else begin
            front_r[pick_idx] <= 1'b0;
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          // Grow the frontier by the unvisited neighbors of the picked hit.
          front_r <= front_r | grow;
          done_r  <= done_r | grow;
          state_r <= S_PICK;
        end
        S_ORD: state_r <= S_OLD;
        S_OLD: begin
          ovalid_r <= 1'b1;
          oidx_r   <= IDX_W'(ok_r[AW-1:0]);
          olbl_r   <= LBL_W'(lbl_rdata_r);
          oflow_r  <= drop_r;
          olast_r  <= (ok_r + CW'(1) == cnt_r);
          state_r  <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_tready) begin
            ovalid_r <= 1'b0;
            ok_r     <= ok_r + CW'(1);
            if (olast_r) begin
              cnt_r   <= '0;
              drop_r  <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_DATA_W-IDX_W-LBL_W){1'b0}}, olbl_r, oidx_r};
  assign out_tuser  = oflow_r;
  assign out_tlast  = olast_r;

  `DWHC_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(MAX_HITS), "hit count beyond capacity")
  `DWHC_NEVER(a_no_in_with_out, clk, rst_n, in_tready && out_tvalid, "hit taken during output")
  `DWHC_ASSERT(a_out_in_range, clk, rst_n, out_tvalid |-> (ok_r < cnt_r), "result index past count")

endmodule

@@ tb/distance_window_hit_clustering_test.sv @@
module distance_window_hit_clustering_test
  import dwhc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HITS_CAP = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [15:0] x, y, z;
    logic        avail;
    logic        last;
  } hit_beat_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [LBL_W-1:0] label;
    logic             ovf;
    logic             last;
  } label_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WIN_W-1:0] cfg_data = '0;

  distance_window_hit_clustering dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hit_beat_t   hit_queue[$];
  label_beat_t label_queue[$];
  int errors = 0;
  int cycles = 0;
  int items = 0;
  bit quiet = 1'b0;

  // Predictor state
  logic [WIN_W-1:0] window_sq = WIN_RESET;
  longint signed pos[HITS_CAP][3];
  int stored = 0;
  bit dropped = 1'b0;

  // Link pairs, label components and queue one expected beat per stored hit
  function automatic void cluster_hits();
    longint unsigned adj[HITS_CAP];
    longint unsigned done, frontier, grow, d2;
    longint signed diff;
    int lbl[HITS_CAP];
    int next;
    label_beat_t b;
    for (int i = 0; i < stored; i++) adj[i] = 0;
    for (int i = 0; i < stored; i++) begin
      for (int j = i + 1; j < stored; j++) begin
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
          diff = pos[i][k] - pos[j][k];
          d2 += longint'(diff * diff);
        end
        if (d2 < window_sq) begin
          adj[i] |= 64'd1 << j;
          adj[j] |= 64'd1 << i;
        end
      end
    end
    done = 0;
    next = 0;
    for (int i = 0; i < stored; i++) begin
      if (!done[i]) begin
        frontier = 64'd1 << i;
        while (frontier != 0) begin
          grow = 0;
          done |= frontier;
          for (int j = 0; j < stored; j++) begin
            if (frontier[j]) begin
              lbl[j] = next;
              grow |= adj[j];
            end
          end
          frontier = grow & ~done;
        end
        next++;
      end
    end
    for (int i = 0; i < stored; i++) begin
      b.idx = i[IDX_W-1:0];
      b.label = lbl[i][LBL_W-1:0];
      b.ovf = dropped;
      b.last = (i == stored - 1);
      label_queue.push_back(b);
    end
  endfunction

  function automatic void absorb_hit(logic [47:0] d, logic avail, logic last);
    if (avail) begin
      if (stored < HITS_CAP) begin
        pos[stored][0] = longint'($signed(d[15:0]));
        pos[stored][1] = longint'($signed(d[31:16]));
        pos[stored][2] = longint'($signed(d[47:32]));
        stored++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (last) begin
      cluster_hits();
      stored = 0;
      dropped = 1'b0;
    end
  endfunction

  // Hit driver with random gap bursts
  int gap = 0;
  always @(posedge clk) begin
    hit_beat_t b;
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet && hit_queue.size() > 0 && $urandom_range(0, 9) == 0) begin
        gap <= $urandom_range(0, 8);
        in_tvalid <= 1'b0;
      end else if (hit_queue.size() > 0) begin
        b = hit_queue.pop_front();
        in_tdata <= {b.z, b.y, b.x};
        in_tuser <= b.avail;
        in_tlast <= b.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Feed accepted hits into the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) absorb_hit(in_tdata, in_tuser, in_tlast);
  end

  // Result sink with random stall bursts, and the checker
  int stall = 0;
  always @(posedge clk) begin
    label_beat_t e;
    if (rst_n) begin
      if (stall > 0) begin
        stall <= stall - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall <= $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (label_queue.size() == 0) begin
          $error("result beat with no expectation: tdata=%h", out_tdata);
          errors++;
        end else begin
          e = label_queue.pop_front();
          if (out_tdata[IDX_W-1:0] !== e.idx) begin
            $error("hit_index expected %0d got %0d", e.idx, out_tdata[IDX_W-1:0]);
            errors++;
          end
          if (out_tdata[IDX_W+LBL_W-1:IDX_W] !== e.label) begin
            $error("cluster_label expected %0d got %0d", e.label,
                   out_tdata[IDX_W+LBL_W-1:IDX_W]);
            errors++;
          end
          if (out_tuser !== e.ovf) begin
            $error("overflow expected %0b got %0b", e.ovf, out_tuser);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last_result expected %0b got %0b", e.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("distance_window_hit_clustering_test: FAIL");
      $finish;
    end
  end

  task automatic push_hit(int x, int y, int z, bit avail, bit last);
    hit_beat_t b;
    b.x = x[15:0];
    b.y = y[15:0];
    b.z = z[15:0];
    b.avail = avail;
    b.last = last;
    hit_queue.push_back(b);
    items++;
  endtask

  // Drain stimulus and results, then let any empty run settle
  task automatic wait_idle();
    while (hit_queue.size() > 0 || in_tvalid || label_queue.size() > 0) @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    window_sq = v;
    cfg_valid <= 1'b0;
  endtask

  // One set around a random center, or now and then spread over the whole range; spread picks how often hits link
  task automatic random_set(int n);
    int cx, cy, cz, spread;
    bit wide;
    wide = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 2))
      0: spread = 8;
      1: spread = 40;
      default: spread = 600;
    endcase
    cx = $urandom();
    cy = $urandom();
    cz = $urandom();
    for (int i = 0; i < n; i++) begin
      if (wide)
        push_hit($urandom(), $urandom(), $urandom(), $urandom_range(0, 9) != 0, i == n - 1);
      else
        push_hit(cx + $urandom_range(0, 2 * spread) - spread,
                 cy + $urandom_range(0, 2 * spread) - spread,
                 cz + $urandom_range(0, 2 * spread) - spread,
                 $urandom_range(0, 9) != 0, i == n - 1);
    end
  endtask

  task automatic random_phase(int count);
    int start;
    start = items;
    while (items - start < count) begin
      if ($urandom_range(0, 19) == 0) random_set($urandom_range(60, 70));
      else random_set($urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [WIN_W-1:0] wins[4];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, a close chain, unavailable hits, empty run
    push_hit(-32768, -32768, -32768, 1, 0);
    push_hit(32767, 32767, 32767, 1, 0);
    push_hit(-32768, 32767, 0, 1, 0);
    push_hit(0, 0, 0, 1, 0);
    push_hit(15, 0, 0, 1, 0);
    push_hit(16, 0, 0, 1, 0);
    push_hit(31, 0, 0, 1, 0);
    push_hit(5, 5, 5, 0, 0);
    push_hit(30, 1, 1, 1, 0);
    push_hit(100, 100, 100, 0, 1);
    push_hit(7, 7, 7, 0, 1);
    push_hit(-1, -1, -1, 1, 1);
    wait_idle();

    // Store full: extra available hits get dropped
    for (int i = 0; i < 68; i++) push_hit(i * 3, -i * 2, i, 1, i == 67);
    wait_idle();

    wins[0] = '0;
    wins[1] = '1;
    wins[2] = 34'd1;
    wins[3] = WIN_W'($urandom_range(100, 20000));
    for (int p = 0; p < 4; p++) begin
      write_window(wins[p]);
      push_hit(0, 0, 0, 1, 0);
      push_hit(0, 0, 0, 1, 0);
      push_hit(-32768, 32767, -32768, 1, 1);
      random_phase(45);
      wait_idle();
    end

    // Back to the reset window, no idling at the end
    write_window(WIN_RESET);
    random_phase(30);
    wait_idle();
    quiet = 1'b1;
    random_phase(20);
    wait_idle();

    if (errors == 0)
      $display("distance_window_hit_clustering_test: PASS");
    else
      $display("distance_window_hit_clustering_test: FAIL");
    $finish;
  end

endmodule
